FILE: hdl/tcw_pkg.sv
// Package for the text console character writer.
// Holds geometry constants, character codes, the operation code and the payload structs.
// No dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STOP = 8;

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int MOVE_COUNT = CELL_COUNT - COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int CNT_W      = $clog2(CELL_COUNT + 1);

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int OFF_W  = 11;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int RADR_W = 11;
  localparam int CELL_W = CHAR_W + ATTR_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'd7;

  typedef enum logic [2:0] {
    OP_READ      = 3'd0,
    OP_PUTC      = 3'd1,
    OP_NEWLINE   = 3'd2,
    OP_RETURN    = 3'd3,
    OP_BACKSPACE = 3'd4,
    OP_TAB       = 3'd5
  } op_t;

  typedef struct packed {
    logic              func;
    logic [CHAR_W-1:0] char_code;
    logic [RADR_W-1:0] read_address;
  } in_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_row;
    logic [OFF_W-1:0]  cursor_offset;
    logic              scrolled;
    logic [CHAR_W-1:0] read_char;
    logic [ATTR_W-1:0] read_attr;
  } out_t;

  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] char_code;
    logic [ADDR_W-1:0] addr;
    logic              in_range;
  } entry_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

FILE: hdl/tcw_front.sv
// Front stage: accepts input transactions and decodes them into queue entries.
// Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tcw_pkg::in_t        in_data,
  input  tcw_pkg::back_stat_t back_stat,
  output logic                push,
  output tcw_pkg::entry_t     push_data,
  input  logic                push_ready
);
  import tcw_pkg::*;

  logic   f_valid_r;
  logic   f_valid_nxt;
  entry_t f_entry_r;
  entry_t f_entry_nxt;
  logic   take;

  assign in_ready  = !back_stat.clearing && (!f_valid_r || push_ready);
  assign take      = in_valid && in_ready;
  assign push      = f_valid_r && push_ready;
  assign push_data = f_entry_r;

  always_comb begin
    f_entry_nxt.char_code = in_data.char_code;
    f_entry_nxt.addr      = ADDR_W'(in_data.read_address);
    f_entry_nxt.in_range  = (32'(in_data.read_address) < CELL_COUNT);
    if (in_data.func) begin
      f_entry_nxt.op = OP_READ;
    end else begin
      unique case (in_data.char_code)
        CH_NEWLINE:   f_entry_nxt.op = OP_NEWLINE;
        CH_RETURN:    f_entry_nxt.op = OP_RETURN;
        CH_BACKSPACE: f_entry_nxt.op = OP_BACKSPACE;
        CH_TAB:       f_entry_nxt.op = OP_TAB;
        default:      f_entry_nxt.op = OP_PUTC;
      endcase
    end
    f_valid_nxt = take || (f_valid_r && !push_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      f_entry_r <= f_entry_nxt;
    end
  end

endmodule

FILE: hdl/tcw_queue.sv
// Short queue of decoded transactions between the front and back stages.
// Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tcw_pkg::entry_t push_data,
  output logic            push_ready,
  input  logic            pop,
  output logic            pop_valid,
  output tcw_pkg::entry_t pop_data
);
  import tcw_pkg::*;

  entry_t             entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r;
  logic [QCNT_W-1:0]  count_nxt;

  assign push_ready = (32'(count_r) < QUEUE_DEPTH);
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= QUEUE_DEPTH) else $error("queue count exceeds depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (32'(count_r) < QUEUE_DEPTH || pop)) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0) else $error("pop from empty queue");
`endif

endmodule

FILE: hdl/tcw_back.sv
// Back stage: cursor state, screen cell memory, scroll and clear sequencer, result register.
// Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  tcw_pkg::entry_t             q_data,
  output logic                        q_pop,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tcw_pkg::ATTR_W-1:0]  cfg_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output tcw_pkg::out_t               out_data,
  output tcw_pkg::back_stat_t         back_stat
);
  import tcw_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_BSWR   = 6'b000100,
    S_SCROLL = 6'b001000,
    S_FILL   = 6'b010000,
    S_POST   = 6'b100000
  } state_t;

  state_t             state_r;
  state_t             state_nxt;
  logic [CELL_W-1:0]  cell_mem_r [CELL_COUNT];
  logic [CELL_W-1:0]  rdata_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_nxt;
  logic [COL_W-1:0]   col_r;
  logic [COL_W-1:0]   col_nxt;
  logic [ROW_W-1:0]   row_r;
  logic [ROW_W-1:0]   row_nxt;
  logic               scr_r;
  logic               scr_nxt;
  logic               rd_ok_r;
  logic               rd_ok_nxt;
  logic [ATTR_W-1:0]  attr_r;
  logic               out_valid_r;
  logic               out_valid_nxt;
  out_t               out_r;
  out_t               out_nxt;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [CELL_W-1:0]  mem_wdata;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_raddr;

  logic [ADDR_W-1:0]  cur_idx;
  logic [COL_W:0]     col_ext;
  logic [COL_W:0]     tab_sum;
  logic [ROW_W:0]     row_ext;
  logic               row_inc;
  logic               bs_move;
  logic               load_out;

  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_data           = out_r;
  assign back_stat.clearing = (state_r == S_CLEAR);
  assign q_pop              = (state_r == S_IDLE) && q_valid;
  assign cur_idx            = ADDR_W'(32'(row_r) * COLUMNS) + ADDR_W'(col_r);
  assign tab_sum            = (COL_W + 1)'(col_r) + (COL_W + 1)'(TAB_STOP);
  assign load_out           = (state_r == S_POST) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    scr_nxt   = scr_r;
    rd_ok_nxt = rd_ok_r;
    mem_we    = 1'b0;
    mem_waddr = cur_idx;
    mem_wdata = {attr_r, q_data.char_code};
    mem_re    = 1'b0;
    mem_raddr = q_data.addr;
    col_ext   = (COL_W + 1)'(col_r);
    row_inc   = 1'b0;
    row_ext   = (ROW_W + 1)'(row_r);
    bs_move   = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r[ADDR_W-1:0];
        mem_wdata = {RESET_ATTR, CH_SPACE};
        cnt_nxt   = cnt_r + 1'b1;
        if (32'(cnt_r) == CELL_COUNT - 1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          scr_nxt   = 1'b0;
          rd_ok_nxt = 1'b0;
          unique case (q_data.op)
            OP_READ: begin
              mem_re    = q_data.in_range;
              rd_ok_nxt = q_data.in_range;
            end
            OP_PUTC: begin
              mem_we  = 1'b1;
              col_ext = (COL_W + 1)'(col_r) + 1'b1;
            end
            OP_NEWLINE: begin
              col_ext = '0;
              row_inc = 1'b1;
            end
            OP_RETURN: begin
              col_ext = '0;
            end
            OP_BACKSPACE: begin
              if (col_r != '0) begin
                bs_move   = 1'b1;
                col_ext   = (COL_W + 1)'(col_r) - 1'b1;
                mem_re    = 1'b1;
                mem_raddr = cur_idx - 1'b1;
                cnt_nxt   = CNT_W'(cur_idx - 1'b1);
              end
            end
            OP_TAB: begin
              col_ext = (COL_W + 1)'(tab_sum - (COL_W + 1)'(tab_sum % TAB_STOP));
            end
            default: begin
              col_ext = (COL_W + 1)'(col_r);
            end
          endcase
          if (32'(col_ext) >= COLUMNS) begin
            col_ext = '0;
            row_inc = 1'b1;
          end
          row_ext = (ROW_W + 1)'(row_r) + (ROW_W + 1)'(row_inc);
          col_nxt = col_ext[COL_W-1:0];
          if (32'(row_ext) >= ROWS) begin
            row_nxt   = ROW_W'(ROWS - 1);
            scr_nxt   = 1'b1;
            cnt_nxt   = '0;
            state_nxt = S_SCROLL;
          end else begin
            row_nxt   = row_ext[ROW_W-1:0];
            state_nxt = bs_move ? S_BSWR : S_POST;
          end
        end
      end
      S_BSWR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r[ADDR_W-1:0];
        mem_wdata = {rdata_r[CELL_W-1:CHAR_W], CH_SPACE};
        state_nxt = S_POST;
      end
      S_SCROLL: begin
        mem_re    = (32'(cnt_r) < MOVE_COUNT);
        mem_raddr = ADDR_W'(cnt_r) + ADDR_W'(COLUMNS);
        mem_we    = (cnt_r != '0);
        mem_waddr = ADDR_W'(cnt_r - 1'b1);
        mem_wdata = rdata_r;
        if (32'(cnt_r) == MOVE_COUNT) begin
          state_nxt = S_FILL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r[ADDR_W-1:0];
        mem_wdata = {attr_r, CH_SPACE};
        cnt_nxt   = cnt_r + 1'b1;
        if (32'(cnt_r) == CELL_COUNT - 1) begin
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_nxt.cursor_column = col_r;
    out_nxt.cursor_row    = row_r;
    out_nxt.cursor_offset = OFF_W'(32'(row_r) * COLUMNS) + OFF_W'(col_r);
    out_nxt.scrolled      = scr_r;
    out_nxt.read_char     = rd_ok_r ? rdata_r[CHAR_W-1:0] : '0;
    out_nxt.read_attr     = rd_ok_r ? rdata_r[CELL_W-1:CHAR_W] : '0;
    out_valid_nxt         = load_out || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      attr_r      <= RESET_ATTR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        attr_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    scr_r   <= scr_nxt;
    rd_ok_r <= rd_ok_nxt;
    if (load_out) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_mem_r[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= cell_mem_r[mem_raddr];
    end
  end

`ifndef NO_ASSERTIONS
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state register is not one-hot");
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(col_r) < COLUMNS) && (32'(row_r) < ROWS)) else $error("cursor out of range");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r != S_CLEAR)) else $error("queue popped into clearing pass");
  a_scroll_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL) |-> scr_r) else $error("fill without scroll flag");
`endif

endmodule

FILE: hdl/text_console_char_writer.sv
// A transaction is registered in the front stage, waits in the queue, is run by the back
// stage and its result is registered; the back stage runs one at a time while the front
// stage and queue take more. Backspace adds a cell rewrite; a scrolling write shifts rows
// up and blanks the bottom row. After reset a clearing pass writes blank cells; no input
// transaction is accepted meanwhile, while configuration writes are taken at any time.
`timescale 1ns / 1ps

module text_console_char_writer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  tcw_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output tcw_pkg::out_t               out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tcw_pkg::ATTR_W-1:0]  cfg_data
);
  import tcw_pkg::*;

  logic       push;
  entry_t     push_data;
  logic       push_ready;
  logic       pop;
  logic       pop_valid;
  entry_t     pop_data;
  back_stat_t back_stat;

  tcw_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .back_stat  (back_stat),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  tcw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data)
  );

  tcw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (pop_valid),
    .q_data    (pop_data),
    .q_pop     (pop),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .back_stat (back_stat)
  );

endmodule

FILE: dv/text_console_char_writer_tb.sv
// Self-checking testbench for text_console_char_writer: a queue-fed driver, a
// monitor holding a cycle-free model of the cell store and cursor, and random handshakes.
// Depends on tcw_pkg and the text_console_char_writer RTL.
`timescale 1ns / 1ps

module text_console_char_writer_tb;
  import tcw_pkg::*;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;
  localparam int SETTLE_CYCLES    = COLUMNS * (ROWS - 1) + 1 + COLUMNS + 64;
  localparam int STALL_LIMIT      = 8 * SETTLE_CYCLES;
  localparam int RANDOM_PER_PHASE = 207;
  localparam int PHASES           = 5;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_t               in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_t              out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [ATTR_W-1:0] cfg_data = '0;

  in_t               pending_items[$];
  out_t              expected_cursors[$];
  logic [CELL_W-1:0] screen_copy[CELL_COUNT];
  int                cursor_col;
  int                cursor_row;
  logic [ATTR_W-1:0] print_attr;
  bit                in_fire;
  bit                calm;
  int                errors;
  int                quiet_cycles;

  text_console_char_writer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic out_t console_step(in_t item);
    out_t res;
    int   idx;
    res = '0;
    if (item.func == FUNC_READ) begin
      if (item.read_address < CELL_COUNT) begin
        res.read_char = screen_copy[item.read_address][CHAR_W-1:0];
        res.read_attr = screen_copy[item.read_address][CELL_W-1:CHAR_W];
      end
    end else begin
      case (item.char_code)
        CH_NEWLINE: begin
          cursor_col = 0;
          cursor_row++;
        end
        CH_RETURN: cursor_col = 0;
        CH_BACKSPACE: begin
          if (cursor_col > 0) begin
            cursor_col--;
            idx = cursor_row * COLUMNS + cursor_col;
            screen_copy[idx][CHAR_W-1:0] = CH_SPACE;
          end
        end
        CH_TAB: cursor_col = (cursor_col + TAB_STOP) - ((cursor_col + TAB_STOP) % TAB_STOP);
        default: begin
          idx = cursor_row * COLUMNS + cursor_col;
          screen_copy[idx] = {print_attr, item.char_code};
          cursor_col++;
        end
      endcase
      if (cursor_col >= COLUMNS) begin
        cursor_col = 0;
        cursor_row++;
      end
      if (cursor_row >= ROWS) begin
        for (int i = 0; i < MOVE_COUNT; i++) screen_copy[i] = screen_copy[i + COLUMNS];
        for (int i = MOVE_COUNT; i < CELL_COUNT; i++) screen_copy[i] = {print_attr, CH_SPACE};
        cursor_row = ROWS - 1;
        res.scrolled = 1'b1;
      end
    end
    res.cursor_column = COL_W'(cursor_col);
    res.cursor_row    = ROW_W'(cursor_row);
    res.cursor_offset = OFF_W'(cursor_row * COLUMNS + cursor_col);
    return res;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  // Monitor: predicts on each input transaction and checks each result transaction.
  always @(posedge clk) begin
    out_t want;
    in_fire = in_valid && in_ready;
    if (cfg_valid && cfg_ready) print_attr = cfg_data;
    if (in_fire) expected_cursors.push_back(console_step(in_data));
    if (out_valid && out_ready) begin
      if (expected_cursors.size() == 0) begin
        $error("result transaction with no pending expectation");
        errors++;
      end else begin
        want = expected_cursors.pop_front();
        check_field("cursor_column", 32'(want.cursor_column), 32'(out_data.cursor_column));
        check_field("cursor_row", 32'(want.cursor_row), 32'(out_data.cursor_row));
        check_field("cursor_offset", 32'(want.cursor_offset), 32'(out_data.cursor_offset));
        check_field("scrolled", 32'(want.scrolled), 32'(out_data.scrolled));
        check_field("read_char", 32'(want.read_char), 32'(out_data.read_char));
        check_field("read_attr", 32'(want.read_attr), 32'(out_data.read_attr));
      end
    end
    if (in_fire || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("text_console_char_writer test failed");
      $finish;
    end
  end

  // Driver: feeds input transactions from the pending queue and throttles out_ready.
  always @(negedge clk) begin
    if (!in_valid || in_fire) begin
      if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= 16)) begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= calm || ($urandom_range(0, 99) >= 16);
  end

  function automatic in_t make_write(logic [CHAR_W-1:0] ch);
    in_t item;
    item.func         = FUNC_WRITE;
    item.char_code    = ch;
    item.read_address = RADR_W'($urandom_range(0, 2047));
    return item;
  endfunction

  function automatic in_t make_read(logic [RADR_W-1:0] addr);
    in_t item;
    item.func         = FUNC_READ;
    item.char_code    = CHAR_W'($urandom_range(0, 255));
    item.read_address = addr;
    return item;
  endfunction

  task automatic queue_random(int count);
    int added;
    int pick;
    int len;
    added = 0;
    while (added < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 100) : $urandom_range(1, 30);
        repeat (len) begin
          if ($urandom_range(0, 7) == 0) begin
            pending_items.push_back(make_write(CHAR_W'($urandom_range(0, 255))));
          end else begin
            pending_items.push_back(make_write(CHAR_W'($urandom_range(32, 126))));
          end
        end
        added += len;
        case ($urandom_range(0, 3))
          0, 1: pending_items.push_back(make_write(CH_NEWLINE));
          2: pending_items.push_back(make_write(CH_RETURN));
          default: pending_items.push_back(make_write(CH_TAB));
        endcase
        added++;
      end else if (pick < 55) begin
        len = $urandom_range(1, 4);
        repeat (len) begin
          if ($urandom_range(0, 4) == 0) begin
            pending_items.push_back(make_read(RADR_W'($urandom_range(0, 2047))));
          end else begin
            pending_items.push_back(make_read(RADR_W'($urandom_range(0, CELL_COUNT - 1))));
          end
        end
        added += len;
      end else if (pick < 70) begin
        len = $urandom_range(1, 5);
        repeat (len) pending_items.push_back(make_write(CH_BACKSPACE));
        added += len;
      end else if (pick < 82) begin
        len = $urandom_range(1, 4);
        repeat (len) pending_items.push_back(make_write(CH_TAB));
        added += len;
      end else if (pick < 87) begin
        len = $urandom_range(1, 25);
        repeat (len) pending_items.push_back(make_write(CH_NEWLINE));
        added += len;
      end else begin
        pending_items.push_back($urandom_range(0, 1)
                                ? make_read(RADR_W'($urandom_range(0, 2047)))
                                : make_write(CHAR_W'($urandom_range(0, 255))));
        added++;
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_cursors.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_attr(logic [ATTR_W-1:0] value);
    @(negedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    for (int i = 0; i < CELL_COUNT; i++) screen_copy[i] = {RESET_ATTR, CH_SPACE};
    cursor_col   = 0;
    cursor_row   = 0;
    print_attr   = RESET_ATTR;
    calm         = 1'b0;
    errors       = 0;
    quiet_cycles = 0;
    in_fire      = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    pending_items.push_back(make_read(11'd0));
    pending_items.push_back(make_read(RADR_W'(CELL_COUNT - 1)));
    pending_items.push_back(make_read(RADR_W'(CELL_COUNT)));
    pending_items.push_back(make_read(11'd2047));
    pending_items.push_back(make_write(8'd0));
    pending_items.push_back(make_write(8'd255));
    pending_items.push_back(make_write(8'd65));
    pending_items.push_back(make_write(CH_BACKSPACE));
    pending_items.push_back(make_write(CH_RETURN));
    pending_items.push_back(make_write(CH_BACKSPACE));
    pending_items.push_back(make_write(CH_TAB));
    pending_items.push_back(make_write(8'd120));
    pending_items.push_back(make_write(CH_TAB));
    pending_items.push_back(make_write(CH_NEWLINE));
    pending_items.push_back(make_read(11'd0));
    pending_items.push_back(make_read(11'd1));
    pending_items.push_back(make_read(11'd2));
    pending_items.push_back(make_read(11'd8));
    queue_random(RANDOM_PER_PHASE);
    wait_idle();

    for (int phase = 1; phase < PHASES; phase++) begin
      case (phase)
        1: write_attr(8'hFF);
        2: write_attr(8'h00);
        default: write_attr(ATTR_W'($urandom_range(1, 254)));
      endcase
      calm = (phase == 2);
      queue_random(RANDOM_PER_PHASE);
      wait_idle();
    end

    if (errors == 0 && expected_cursors.size() == 0) begin
      $display("text_console_char_writer test passed");
    end else begin
      $display("text_console_char_writer test failed");
    end
    $finish;
  end

endmodule
